FILE: rtl/nps_pkg.sv
// Shared types, widths and constants of the priority scheduler.
`timescale 1ns / 1ps

package nps_pkg;

    localparam int MAX_JOBS_DEF = 16;

    localparam int ID_W   = 8;
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 12;
    localparam int PRIO_W = 8;
    localparam int TIME_W = 17;
    localparam int TOT_W  = 21;

    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [TOT_W-1:0]  TOTAL_MAX = {TOT_W{1'b1}};

    // One loaded item
    typedef struct packed {
        logic [ID_W-1:0]   job_id;
        logic [ARR_W-1:0]  arrival_time;
        logic [BUR_W-1:0]  burst_length;
        logic [PRIO_W-1:0] job_priority;
        logic              last_job;
    } t_job_item;

    // One table entry
    typedef struct packed {
        logic [ID_W-1:0]   job_id;
        logic [ARR_W-1:0]  arrival_time;
        logic [BUR_W-1:0]  burst_length;
        logic [PRIO_W-1:0] job_priority;
    } t_job_rec;

    // One result item
    typedef struct packed {
        logic [ID_W-1:0]   out_job_id;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] idle_before;
        logic [TOT_W-1:0]  sum_completion;
        logic [TOT_W-1:0]  sum_turnaround;
        logic [TOT_W-1:0]  sum_waiting;
        logic              last_result;
    } t_res_item;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_CALC,
        ST_EMIT
    } t_state;

endpackage

FILE: rtl/nps_job_if.sv
// Input channel carrying job items.
`timescale 1ns / 1ps

interface nps_job_if;
    logic              valid;
    logic              ready;
    nps_pkg::t_job_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/nps_res_if.sv
// Output channel carrying schedule result items.
`timescale 1ns / 1ps

interface nps_res_if;
    logic              valid;
    logic              ready;
    nps_pkg::t_res_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/nonpreemptive_priority_scheduler.sv
// Top level: loads a job set into a table and emits its non-preemptive priority schedule.
//
//  channel  dir  payload      handshake
//  i_job    in   t_job_item   valid/ready, taken only while loading
//  o_res    out  t_res_item   valid/ready, held in an output register
//
// Loading takes one item per cycle. After the item marked last, each result
// takes one table read per stored entry through the single memory read port,
// a registered read, one timing step and one write-back step. Reset
// (synchronous, active low) clears the count, the scheduled flags, the clock
// and the totals; the table needs no clearing. A stalled result holds the
// write-back step until the output register frees.
`timescale 1ns / 1ps

module nonpreemptive_priority_scheduler #(
    parameter int MAX_JOBS = nps_pkg::MAX_JOBS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nps_job_if.sink    i_job,
    nps_res_if.source  o_res
);

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JOBS);

    localparam int TIME_W = nps_pkg::TIME_W;
    localparam int TOT_W  = nps_pkg::TOT_W;
    localparam int BUR_W  = nps_pkg::BUR_W;
    localparam int ID_W   = nps_pkg::ID_W;

    nps_pkg::t_state r_state, n_state;

    // Batch state
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_emitted;
    logic [MAX_JOBS-1:0] r_sched;
    logic [TIME_W-1:0]   r_time;
    logic [TOT_W-1:0]    r_sum_comp, r_sum_tat, r_sum_wait;

    // Scan state
    logic [CNT_W-1:0]  r_scan_cnt;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;

    // Best arrived job
    logic              r_have_rdy;
    logic [IDX_W-1:0]  r_rdy_idx;
    nps_pkg::t_job_rec r_rdy_rec;
    // Best among earliest unscheduled arrivals
    logic              r_have_e;
    logic [IDX_W-1:0]  r_e_idx;
    nps_pkg::t_job_rec r_e_rec;

    // Timing step results
    logic [IDX_W-1:0]  r_pick_idx;
    logic [ID_W-1:0]   r_pick_id;
    logic [TIME_W-1:0] r_start, r_done, r_tat, r_wait, r_idle;

    // Output register
    logic               r_out_vld;
    nps_pkg::t_res_item r_out;

    // Control
    logic w_accept, w_store, w_scan_issue, w_scan_begin, w_out_load, w_last;
    logic w_out_free;

    nps_pkg::t_job_rec w_wr_rec, w_rd_rec;

    assign w_accept   = i_job.valid && i_job.ready;
    assign w_store    = w_accept && (r_count < CNT_MAX);
    assign w_out_free = !r_out_vld || o_res.ready;
    assign w_last     = (CNT_W'(r_emitted + 1'b1) == r_count);

    assign w_wr_rec.job_id       = i_job.data.job_id;
    assign w_wr_rec.arrival_time = i_job.data.arrival_time;
    assign w_wr_rec.burst_length = i_job.data.burst_length;
    assign w_wr_rec.job_priority = i_job.data.job_priority;

    nps_job_mem #(
        .DEPTH  (MAX_JOBS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_store),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (w_wr_rec),
        .i_rd_en   (w_scan_issue),
        .i_rd_addr (r_scan_cnt[IDX_W-1:0]),
        .o_rd_data (w_rd_rec)
    );

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nps_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence load, scan, timing and write-back
    always_comb begin
        n_state      = r_state;
        i_job.ready  = 1'b0;
        w_scan_issue = 1'b0;
        w_scan_begin = 1'b0;
        w_out_load   = 1'b0;
        case (r_state)
            nps_pkg::ST_LOAD: begin
                i_job.ready = 1'b1;
                if (i_job.valid && i_job.data.last_job) begin
                    w_scan_begin = 1'b1;
                    n_state      = nps_pkg::ST_SCAN;
                end
            end
            nps_pkg::ST_SCAN: begin
                w_scan_issue = 1'b1;
                if (r_scan_cnt == CNT_W'(r_count - 1'b1)) begin
                    n_state = nps_pkg::ST_DRAIN;
                end
            end
            nps_pkg::ST_DRAIN: begin
                n_state = nps_pkg::ST_CALC;
            end
            nps_pkg::ST_CALC: begin
                n_state = nps_pkg::ST_EMIT;
            end
            nps_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    if (w_last) begin
                        n_state = nps_pkg::ST_LOAD;
                    end else begin
                        w_scan_begin = 1'b1;
                        n_state      = nps_pkg::ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = nps_pkg::ST_LOAD;
            end
        endcase
    end

    // Candidate tests on the entry coming back from the table
    logic w_unsched, w_ready_now, w_upd_rdy, w_upd_e;

    assign w_unsched   = !r_sched[r_cmp_idx];
    assign w_ready_now = w_unsched && ({1'b0, w_rd_rec.arrival_time} <= r_time);
    assign w_upd_rdy   = r_cmp_vld && w_ready_now &&
                         (!r_have_rdy || (w_rd_rec.job_priority < r_rdy_rec.job_priority));
    assign w_upd_e     = r_cmp_vld && w_unsched &&
                         (!r_have_e ||
                          (w_rd_rec.arrival_time < r_e_rec.arrival_time) ||
                          ((w_rd_rec.arrival_time == r_e_rec.arrival_time) &&
                           (w_rd_rec.job_priority < r_e_rec.job_priority)));

    // Advance the scan and keep both best candidates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
            r_cmp_vld  <= 1'b0;
            r_have_rdy <= 1'b0;
            r_have_e   <= 1'b0;
        end else begin
            r_cmp_vld <= w_scan_issue;
            if (w_scan_begin) begin
                r_scan_cnt <= '0;
                r_have_rdy <= 1'b0;
                r_have_e   <= 1'b0;
            end else begin
                if (w_scan_issue) begin
                    r_scan_cnt <= CNT_W'(r_scan_cnt + 1'b1);
                end
                if (w_upd_rdy) begin
                    r_have_rdy <= 1'b1;
                end
                if (w_upd_e) begin
                    r_have_e <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan_issue) begin
            r_cmp_idx <= r_scan_cnt[IDX_W-1:0];
        end
        if (w_upd_rdy) begin
            r_rdy_idx <= r_cmp_idx;
            r_rdy_rec <= w_rd_rec;
        end
        if (w_upd_e) begin
            r_e_idx <= r_cmp_idx;
            r_e_rec <= w_rd_rec;
        end
    end

    // Timing step: pick the job, jump over idle time if nothing has arrived
    logic [TIME_W-1:0] w_start, w_idle, w_done, w_arr;
    logic [TIME_W:0]   w_done_sum;
    logic [BUR_W-1:0]  w_burst;

    always_comb begin
        if (r_have_rdy) begin
            w_start = r_time;
            w_idle  = '0;
            w_arr   = TIME_W'(r_rdy_rec.arrival_time);
            w_burst = r_rdy_rec.burst_length;
        end else begin
            w_start = TIME_W'(r_e_rec.arrival_time);
            w_idle  = TIME_W'(r_e_rec.arrival_time) - r_time;
            w_arr   = TIME_W'(r_e_rec.arrival_time);
            w_burst = r_e_rec.burst_length;
        end
        w_done_sum = {1'b0, w_start} + (TIME_W + 1)'(w_burst);
        w_done     = w_done_sum[TIME_W] ? nps_pkg::TIME_MAX : w_done_sum[TIME_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == nps_pkg::ST_CALC) begin
            r_pick_idx <= r_have_rdy ? r_rdy_idx : r_e_idx;
            r_pick_id  <= r_have_rdy ? r_rdy_rec.job_id : r_e_rec.job_id;
            r_start    <= w_start;
            r_done     <= w_done;
            r_idle     <= w_idle;
            r_tat      <= w_done - w_arr;
            r_wait     <= w_start - w_arr;
        end
    end

    // Saturating running totals
    logic [TOT_W:0]   w_comp_sum, w_tat_sum, w_wait_sum;
    logic [TOT_W-1:0] n_sum_comp, n_sum_tat, n_sum_wait;

    always_comb begin
        w_comp_sum = {1'b0, r_sum_comp} + (TOT_W + 1)'(r_done);
        w_tat_sum  = {1'b0, r_sum_tat}  + (TOT_W + 1)'(r_tat);
        w_wait_sum = {1'b0, r_sum_wait} + (TOT_W + 1)'(r_wait);
        n_sum_comp = w_comp_sum[TOT_W] ? nps_pkg::TOTAL_MAX : w_comp_sum[TOT_W-1:0];
        n_sum_tat  = w_tat_sum[TOT_W]  ? nps_pkg::TOTAL_MAX : w_tat_sum[TOT_W-1:0];
        n_sum_wait = w_wait_sum[TOT_W] ? nps_pkg::TOTAL_MAX : w_wait_sum[TOT_W-1:0];
    end

    // Write back batch state; drop it all after the final result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_emitted  <= '0;
            r_sched    <= '0;
            r_time     <= '0;
            r_sum_comp <= '0;
            r_sum_tat  <= '0;
            r_sum_wait <= '0;
        end else if (w_out_load && w_last) begin
            r_count    <= '0;
            r_emitted  <= '0;
            r_sched    <= '0;
            r_time     <= '0;
            r_sum_comp <= '0;
            r_sum_tat  <= '0;
            r_sum_wait <= '0;
        end else if (w_out_load) begin
            r_emitted            <= CNT_W'(r_emitted + 1'b1);
            r_sched[r_pick_idx]  <= 1'b1;
            r_time               <= r_done;
            r_sum_comp           <= n_sum_comp;
            r_sum_tat            <= n_sum_tat;
            r_sum_wait           <= n_sum_wait;
        end else if (w_store) begin
            r_count <= CNT_W'(r_count + 1'b1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.out_job_id      <= r_pick_id;
            r_out.start_time      <= r_start;
            r_out.completion_time <= r_done;
            r_out.turnaround      <= r_tat;
            r_out.waiting         <= r_wait;
            r_out.idle_before     <= r_idle;
            r_out.sum_completion  <= n_sum_comp;
            r_out.sum_turnaround  <= n_sum_tat;
            r_out.sum_waiting     <= n_sum_wait;
            r_out.last_result     <= w_last;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("job count beyond table depth");

    a_candidate_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nps_pkg::ST_CALC) |-> (r_have_rdy || r_have_e))
        else $error("scan ended without an unscheduled job");

    a_pick_unscheduled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nps_pkg::ST_EMIT) |-> !r_sched[r_pick_idx])
        else $error("picked job already scheduled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_res.ready) |=> $stable(r_out))
        else $error("result overwritten while stalled");

    a_batch_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && w_last) |=> (r_count == '0 && r_sched == '0 && r_time == '0))
        else $error("batch state not cleared after final result");
`endif

endmodule

FILE: rtl/nps_job_mem.sv
// Job table: one write port, one registered read port.
`timescale 1ns / 1ps

module nps_job_mem #(
    parameter int DEPTH  = nps_pkg::MAX_JOBS_DEF,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  nps_pkg::t_job_rec i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output nps_pkg::t_job_rec o_rd_data
);

    nps_pkg::t_job_rec r_mem [DEPTH];
    nps_pkg::t_job_rec r_rd_data;

    // Store an entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sim/tb_top.sv
// Testbench for the non-preemptive priority scheduler: job set stimulus and result scoreboard.
`timescale 1ns / 1ps

module tb_top;

    localparam int JOB_SLOTS    = nps_pkg::MAX_JOBS_DEF;
    localparam int RANDOM_ITEMS = 85;
    localparam int QUIET_ITEMS  = 20;

    localparam int ID_W   = nps_pkg::ID_W;
    localparam int ARR_W  = nps_pkg::ARR_W;
    localparam int BUR_W  = nps_pkg::BUR_W;
    localparam int PRIO_W = nps_pkg::PRIO_W;
    localparam int TIME_W = nps_pkg::TIME_W;
    localparam int TOT_W  = nps_pkg::TOT_W;

    logic i_clk;
    logic i_rst_n;

    nps_job_if job_if ();
    nps_res_if res_if ();

    nonpreemptive_priority_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_if),
        .o_res   (res_if)
    );

    // Shadow job table of the set being loaded
    nps_pkg::t_job_rec  job_tab [JOB_SLOTS];
    int                 loaded_cnt;
    // Schedule entries still owed by the block, oldest first
    nps_pkg::t_res_item sched_expect [$];
    int                 mismatch_cnt;

    // Idling knobs, changed from the test sequence
    bit quiet_phase;
    bit tx_gaps;
    bit rx_stalls;
    int stall_left;

    // Generate the clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Arrived, unscheduled job with the smallest priority, earliest loaded on ties
    function automatic int pick_ready_job(input int now, input bit done_flag [JOB_SLOTS]);
        int best;
        best = -1;
        for (int k = 0; k < loaded_cnt; k++) begin
            if (!done_flag[k] && int'(job_tab[k].arrival_time) <= now) begin
                if (best < 0 || job_tab[k].job_priority < job_tab[best].job_priority)
                    best = k;
            end
        end
        return best;
    endfunction

    // Store one item and, on the last one, work out the whole schedule of the set
    function automatic void load_and_schedule(input nps_pkg::t_job_item item);
        bit                 done_flag [JOB_SLOTS];
        int                 now, idle, start, finish, pick, early;
        int                 tot_c, tot_t, tot_w;
        nps_pkg::t_res_item entry;
        now   = 0;
        tot_c = 0;
        tot_t = 0;
        tot_w = 0;
        foreach (done_flag[k]) done_flag[k] = 1'b0;
        if (loaded_cnt < JOB_SLOTS) begin
            job_tab[loaded_cnt].job_id       = item.job_id;
            job_tab[loaded_cnt].arrival_time = item.arrival_time;
            job_tab[loaded_cnt].burst_length = item.burst_length;
            job_tab[loaded_cnt].job_priority = item.job_priority;
            loaded_cnt++;
        end
        if (!item.last_job)
            return;
        for (int n = 0; n < loaded_cnt; n++) begin
            idle = 0;
            pick = pick_ready_job(now, done_flag);
            if (pick < 0) begin
                // Nothing ready: jump ahead to the earliest pending arrival
                early = -1;
                for (int k = 0; k < loaded_cnt; k++) begin
                    if (!done_flag[k] && (early < 0 ||
                        job_tab[k].arrival_time < job_tab[early].arrival_time))
                        early = k;
                end
                idle = int'(job_tab[early].arrival_time) - now;
                now  = int'(job_tab[early].arrival_time);
                pick = pick_ready_job(now, done_flag);
            end
            start  = now;
            finish = start + int'(job_tab[pick].burst_length);
            if (finish > int'(nps_pkg::TIME_MAX)) finish = int'(nps_pkg::TIME_MAX);
            now = finish;
            done_flag[pick] = 1'b1;
            tot_c = tot_c + finish;
            tot_t = tot_t + finish - int'(job_tab[pick].arrival_time);
            tot_w = tot_w + start - int'(job_tab[pick].arrival_time);
            if (tot_c > int'(nps_pkg::TOTAL_MAX)) tot_c = int'(nps_pkg::TOTAL_MAX);
            if (tot_t > int'(nps_pkg::TOTAL_MAX)) tot_t = int'(nps_pkg::TOTAL_MAX);
            if (tot_w > int'(nps_pkg::TOTAL_MAX)) tot_w = int'(nps_pkg::TOTAL_MAX);
            entry.out_job_id      = job_tab[pick].job_id;
            entry.start_time      = TIME_W'(start);
            entry.completion_time = TIME_W'(finish);
            entry.turnaround      = TIME_W'(finish - int'(job_tab[pick].arrival_time));
            entry.waiting         = TIME_W'(start - int'(job_tab[pick].arrival_time));
            entry.idle_before     = TIME_W'(idle);
            entry.sum_completion  = TOT_W'(tot_c);
            entry.sum_turnaround  = TOT_W'(tot_t);
            entry.sum_waiting     = TOT_W'(tot_w);
            entry.last_result     = (n + 1 == loaded_cnt);
            sched_expect = {sched_expect, entry};
        end
        loaded_cnt = 0;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_cnt++;
        end
    endfunction

    // Compare each accepted result item with the oldest expected entry
    always @(posedge i_clk) begin
        nps_pkg::t_res_item want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (sched_expect.size() == 0) begin
                $error("unexpected result item: out_job_id %0d", res_if.data.out_job_id);
                mismatch_cnt++;
            end else begin
                want = sched_expect.pop_front();
                check_field("out_job_id", 32'(want.out_job_id),
                            32'(res_if.data.out_job_id));
                check_field("start_time", 32'(want.start_time),
                            32'(res_if.data.start_time));
                check_field("completion_time", 32'(want.completion_time),
                            32'(res_if.data.completion_time));
                check_field("turnaround", 32'(want.turnaround),
                            32'(res_if.data.turnaround));
                check_field("waiting", 32'(want.waiting), 32'(res_if.data.waiting));
                check_field("idle_before", 32'(want.idle_before),
                            32'(res_if.data.idle_before));
                check_field("sum_completion", 32'(want.sum_completion),
                            32'(res_if.data.sum_completion));
                check_field("sum_turnaround", 32'(want.sum_turnaround),
                            32'(res_if.data.sum_turnaround));
                check_field("sum_waiting", 32'(want.sum_waiting),
                            32'(res_if.data.sum_waiting));
                check_field("last_result", 32'(want.last_result),
                            32'(res_if.data.last_result));
            end
        end
    end

    // Drive result ready, with random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            res_if.ready  <= 1'b0;
        end else if (!quiet_phase && rx_stalls && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 14);
            res_if.ready  <= 1'b0;
        end else begin
            res_if.ready  <= 1'b1;
        end
    end

    function automatic nps_pkg::t_job_item make_job(input int id, input int arr,
                                                    input int burst, input int prio,
                                                    input bit last);
        nps_pkg::t_job_item item;
        item.job_id       = ID_W'(id);
        item.arrival_time = ARR_W'(arr);
        item.burst_length = BUR_W'(burst);
        item.job_priority = PRIO_W'(prio);
        item.last_job     = last;
        return item;
    endfunction

    // Offer one item, hold it until accepted, then predict; valid stays high on return
    task automatic send_job(input nps_pkg::t_job_item item);
        if (!quiet_phase && tx_gaps && $urandom_range(0, 3) == 0) begin
            job_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        job_if.valid <= 1'b1;
        job_if.data  <= item;
        do @(posedge i_clk); while (!job_if.ready);
        load_and_schedule(item);
    endtask

    task automatic job_idle();
        job_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold the sender until every expected result has arrived
    task automatic wait_drained();
        job_idle();
        while (sched_expect.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_single_extremes();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        send_job(make_job(255, 65535, 4095, 255, 1'b1));
        send_job(make_job(0, 0, 0, 0, 1'b1));
        wait_drained();
    endtask

    // Priority tie, idle gaps at start and middle, zero burst
    task automatic test_ties_idle_zero_burst();
        send_job(make_job(1, 10, 0, 5, 1'b0));
        send_job(make_job(2, 10, 3, 5, 1'b0));
        send_job(make_job(3, 10, 2, 1, 1'b0));
        send_job(make_job(4, 100, 7, 0, 1'b1));
        wait_drained();
    endtask

    // Fill every slot, then drop two more items, the second closing the set
    task automatic test_table_full();
        for (int k = 0; k < JOB_SLOTS; k++)
            send_job(make_job($urandom_range(0, 255), $urandom_range(0, 400),
                              $urandom_range(0, 4095), $urandom_range(0, 7), 1'b0));
        send_job(make_job(170, 3, 5, 0, 1'b0));
        send_job(make_job(85, 7, 9, 0, 1'b1));
        wait_drained();
    endtask

    // One job set with random size and content shaped per set
    task automatic send_random_set(input int set_size);
        int                 arr_mode, prio_span, burst_span, base;
        nps_pkg::t_job_item item;
        arr_mode   = $urandom_range(0, 2);
        prio_span  = $urandom_range(0, 1) ? 3 : 255;
        burst_span = $urandom_range(0, 1) ? 20 : 4095;
        base       = $urandom_range(0, 65535 - 300);
        for (int k = 0; k < set_size; k++) begin
            item.job_id = ID_W'($urandom_range(0, 255));
            case (arr_mode)
                0:       item.arrival_time = ARR_W'(base + $urandom_range(0, 300));
                1:       item.arrival_time = ARR_W'($urandom_range(0, 65535));
                default: item.arrival_time = ARR_W'(base);
            endcase
            item.burst_length = BUR_W'($urandom_range(0, burst_span));
            item.job_priority = PRIO_W'($urandom_range(0, prio_span));
            item.last_job     = (k == set_size - 1);
            send_job(item);
        end
    endtask

    task automatic test_random_sets(input int item_goal);
        int sent, set_size;
        sent = 0;
        while (sent < item_goal) begin
            tx_gaps   = $urandom_range(0, 3) != 0;
            rx_stalls = $urandom_range(0, 3) != 0;
            // Mostly fitting sets, now and then an overfull one
            set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 19)
                                                   : $urandom_range(1, JOB_SLOTS);
            send_random_set(set_size);
            sent += (set_size > JOB_SLOTS) ? JOB_SLOTS : set_size;
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end
    endtask

    task automatic test_quiet_tail(input int item_goal);
        int sent, set_size;
        quiet_phase = 1'b1;
        sent = 0;
        while (sent < item_goal) begin
            set_size = $urandom_range(1, 8);
            send_random_set(set_size);
            sent += set_size;
        end
    endtask

    // Run sequence
    initial begin
        i_rst_n      = 1'b0;
        job_if.valid = 1'b0;
        job_if.data  = '0;
        res_if.ready = 1'b0;
        loaded_cnt   = 0;
        mismatch_cnt = 0;
        quiet_phase  = 1'b0;
        tx_gaps      = 1'b0;
        rx_stalls    = 1'b0;
        stall_left   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_extremes();
        test_ties_idle_zero_burst();
        test_table_full();
        test_random_sets(RANDOM_ITEMS);
        test_quiet_tail(QUIET_ITEMS);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_cnt == 0 && sched_expect.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Abort a hung run
    initial begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
rtl/nps_pkg.sv
rtl/nps_job_if.sv
rtl/nps_res_if.sv
rtl/nps_job_mem.sv
rtl/nonpreemptive_priority_scheduler.sv
sim/tb_top.sv
